### design/ppds_pkg.sv
// ----------------------------------------------------------------------------
// ppds_pkg
// Shared types and constants of the point projection, depth test and shade
// core: configuration record, input point, and the job passed front to back.
// ----------------------------------------------------------------------------
package ppds_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_ROTATION = 3'd0;
    localparam logic [2:0] REG_ZOOM     = 3'd1;
    localparam logic [2:0] REG_TILT     = 3'd2;
    localparam logic [2:0] REG_LIGHT    = 3'd3;
    localparam logic [2:0] REG_CONTRAST = 3'd4;
    localparam logic [2:0] REG_WIDTH    = 3'd5;
    localparam logic [2:0] REG_HEIGHT   = 3'd6;
    localparam logic [2:0] REG_PALETTE  = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Reset values of the registers
    localparam logic [63:0] RST_ROTATION = 64'h4000_0000_4000_0000;
    localparam logic [15:0] RST_ZOOM     = 16'd256;
    localparam logic [15:0] RST_TILT     = 16'd2458;
    localparam logic [31:0] RST_LIGHT    = 32'd751637299;
    localparam logic [15:0] RST_CONTRAST = 16'd5120;
    localparam logic [8:0]  RST_WIDTH    = 9'd80;
    localparam logic [7:0]  RST_HEIGHT   = 8'd24;
    localparam logic [6:0]  RST_PALETTE  = 7'd12;

    // Item kinds
    localparam logic KIND_DRAW  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // Camera distance 25.0 in Q49
    localparam logic signed [67:0] CAM_DIST = 68'sd25 <<< 49;

    // Front arithmetic chain length and divider length
    localparam int FRONT_STEPS = 8;
    localparam int DIV_STEPS   = 16;
    localparam int QUEUE_DEPTH = 2;

    // Reciprocal depth saturates at or below this Q16 depth
    localparam logic [33:0] SAT_DEPTH = 34'd65536;

    typedef struct packed {
        logic [63:0] rotation;
        logic [15:0] zoom;
        logic [15:0] tilt;
        logic [31:0] light;
        logic [15:0] contrast;
        logic [8:0]  screen_width;
        logic [7:0]  screen_height;
        logic [6:0]  palette_length;
    } t_cfg;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] point_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
    } t_point;

    // Classified item handed to the back end
    typedef struct packed {
        logic               kind;
        logic               fz_pos;
        logic [33:0]        fz16;
        logic signed [22:0] rx8;
        logic signed [25:0] fy8;
        logic [5:0]         level;
    } t_job;

endpackage

### design/ppds_ram.sv
// ----------------------------------------------------------------------------
// ppds_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ppds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/ppds_fifo.sv
// ----------------------------------------------------------------------------
// ppds_fifo
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module ppds_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ppds_pkg::t_job i_data,
    output logic           o_full,
    input  logic           i_pop,
    output ppds_pkg::t_job o_data,
    output logic           o_empty
);
    import ppds_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_job          r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [PW:0]   r_count;

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full  = (r_count == (PW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rptr];

endmodule

### design/ppds_front.sv
// ----------------------------------------------------------------------------
// ppds_front
// Accepts items, runs the shear, rotation and lighting arithmetic as a
// chain of registered multiply and add steps, and queues the result.
// ----------------------------------------------------------------------------
module ppds_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ppds_pkg::t_cfg   i_cfg,
    input  logic             i_hold,
    input  logic             i_valid,
    output logic             o_ready,
    input  ppds_pkg::t_point i_point,
    output logic             o_push,
    output ppds_pkg::t_job   o_job,
    input  logic             i_full
);
    import ppds_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_CALC = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    localparam int SW = $clog2(FRONT_STEPS);

    t_fstate       r_state;
    t_fstate       n_state;
    logic [SW-1:0] r_step;
    t_point        r_in;

    logic signed [15:0] ca, sa, cb, sb, tl, ly, lx;

    logic signed [31:0] r_m_ytl, r_m_zsb, r_m_zcb, r_m_yca, r_m_ysa;
    logic signed [31:0] r_m_nxcb, r_m_nzsb, r_m_nxsb, r_m_nzcb, r_m_nyca;
    logic signed [32:0] r_x1, r_nrx, r_nrz;
    logic signed [48:0] r_m_x1cb, r_m_x1sb, r_m_nrzsa, r_m_nrxlx;
    logic signed [49:0] r_rx, r_rz, r_nfy;
    logic signed [65:0] r_m_rzsa, r_m_rzca, r_m_nfyly;
    logic signed [66:0] r_fy;
    logic signed [67:0] r_fz;
    logic signed [66:0] lum_sum;
    logic signed [24:0] r_lum;
    logic signed [41:0] r_m_lumc;
    logic signed [19:0] lv;
    logic [6:0]         plc;
    logic [5:0]         lvl;

    assign ca = i_cfg.rotation[63:48];
    assign sa = i_cfg.rotation[47:32];
    assign cb = i_cfg.rotation[31:16];
    assign sb = i_cfg.rotation[15:0];
    assign tl = i_cfg.tilt;
    assign ly = i_cfg.light[31:16];
    assign lx = i_cfg.light[15:0];

    // Hold the accepted item
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_point;
        end
    end

    // Arithmetic chain of registered multiply and add steps on the held item
    always_ff @(posedge i_clk) begin
        r_m_ytl  <= r_in.point_y * tl;
        r_m_zsb  <= r_in.point_z * sb;
        r_m_zcb  <= r_in.point_z * cb;
        r_m_yca  <= r_in.point_y * ca;
        r_m_ysa  <= r_in.point_y * sa;
        r_m_nxcb <= r_in.normal_x * cb;
        r_m_nzsb <= r_in.normal_z * sb;
        r_m_nxsb <= r_in.normal_x * sb;
        r_m_nzcb <= r_in.normal_z * cb;
        r_m_nyca <= r_in.normal_y * ca;

        r_x1  <= 33'($signed({r_in.point_x, 13'd0})) + 33'(r_m_ytl);
        r_nrx <= 33'(r_m_nxcb) - 33'(r_m_nzsb);
        r_nrz <= 33'(r_m_nxsb) + 33'(r_m_nzcb);

        r_m_x1cb  <= r_x1 * cb;
        r_m_x1sb  <= r_x1 * sb;
        r_m_nrzsa <= r_nrz * sa;
        r_m_nrxlx <= r_nrx * lx;

        r_rx  <= 50'(r_m_x1cb) - 50'($signed({r_m_zsb, 13'd0}));
        r_rz  <= 50'(r_m_x1sb) + 50'($signed({r_m_zcb, 13'd0}));
        r_nfy <= 50'($signed({r_m_nyca, 14'd0})) - 50'(r_m_nrzsa);

        r_m_rzsa  <= r_rz * sa;
        r_m_rzca  <= r_rz * ca;
        r_m_nfyly <= r_nfy * ly;

        r_fy  <= 67'($signed({r_m_yca, 27'd0})) - 67'(r_m_rzsa);
        r_fz  <= 68'($signed({r_m_ysa, 27'd0})) + 68'(r_m_rzca) + CAM_DIST;
        r_lum <= lum_sum[66:42];

        r_m_lumc <= r_lum * $signed({1'b0, i_cfg.contrast});
    end

    // Luminance sum and shade clamp
    always_comb begin
        lum_sum = 67'(r_m_nfyly) + 67'($signed({r_m_nrxlx, 14'd0}));
        lv      = r_m_lumc[41:22];
        if (i_cfg.palette_length == 7'd0) begin
            plc = 7'd1;
        end else if (i_cfg.palette_length > 7'd64) begin
            plc = 7'd64;
        end else begin
            plc = i_cfg.palette_length;
        end
        if (lv[19]) begin
            lvl = 6'd0;
        end else if (lv[18:0] >= 19'(plc)) begin
            lvl = 6'(plc - 7'd1);
        end else begin
            lvl = lv[5:0];
        end
    end

    // Sequence: accept, let the chain settle for a drawn point, push
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (i_valid && o_ready) begin
                    n_state = (i_point.kind == KIND_CLEAR) ? F_PUSH : F_CALC;
                end
            end
            F_CALC: begin
                if (r_step == SW'(FRONT_STEPS - 1)) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= (r_state == F_CALC) ? r_step + 1'b1 : '0;
        end
    end

    assign o_ready = (r_state == F_IDLE) && !i_hold;
    assign o_push  = (r_state == F_PUSH) && !i_full;

    assign o_job.kind   = r_in.kind;
    assign o_job.fz_pos = !r_fz[67] && (r_fz != '0);
    assign o_job.fz16   = r_fz[66:33];
    assign o_job.rx8    = r_rx[49:27];
    assign o_job.fy8    = r_fy[66:41];
    assign o_job.level  = lvl;

endmodule

### design/ppds_back.sv
// ----------------------------------------------------------------------------
// ppds_back
// Takes queued jobs: clears the depth store, or divides for reciprocal
// depth, projects, bounds-checks, depth-tests and emits a result item.
// ----------------------------------------------------------------------------
module ppds_back #(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 128
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ppds_pkg::t_cfg i_cfg,
    input  logic           i_job_valid,
    input  ppds_pkg::t_job i_job,
    output logic           o_job_pop,
    output logic           o_clearing,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [14:0]    o_cell_index,
    output logic [5:0]     o_shade_index
);
    import ppds_pkg::*;

    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CI    = $clog2(MAX_COLUMNS);
    localparam int RI    = $clog2(MAX_ROWS);
    localparam int CWN   = $clog2(MAX_COLUMNS + 1);
    localparam int RWN   = $clog2(MAX_ROWS + 1);
    localparam int WW    = (CWN > 9) ? CWN : 9;
    localparam int HW    = (RWN > 8) ? RWN : 8;
    localparam int DCW   = $clog2(DIV_STEPS);

    typedef enum logic [8:0] {
        B_CLEAR = 9'b000000001,
        B_IDLE  = 9'b000000010,
        B_DIV   = 9'b000000100,
        B_PROJ  = 9'b000001000,
        B_BOUND = 9'b000010000,
        B_ADDR  = 9'b000100000,
        B_READ  = 9'b001000000,
        B_TEST  = 9'b010000000,
        B_EMIT  = 9'b100000000
    } t_bstate;

    t_bstate  r_state;
    t_bstate  n_state;
    logic [AW-1:0]  r_clr_addr;
    logic [DCW-1:0] r_div_cnt;
    logic           r_out_valid;

    logic [34:0]        r_rem;
    logic [15:0]        r_quo;
    logic [33:0]        r_div;
    logic               r_sat;
    logic signed [39:0] r_mx;
    logic signed [42:0] r_my;
    logic [5:0]         r_level;
    logic signed [58:0] r_sxp;
    logic signed [61:0] r_syp;
    logic [CI-1:0]      r_col;
    logic [RI-1:0]      r_row;
    logic [AW-1:0]      r_idx;
    logic [14:0]        r_out_cell;
    logic [5:0]         r_out_shade;

    logic [WW-1:0]      w;
    logic [HW-1:0]      h;
    logic [15:0]        ooz;
    logic [34:0]        dtry;
    logic               dge;
    logic signed [56:0] px;
    logic signed [59:0] py;
    logic               x_neg, y_neg, ok_x, ok_y;
    logic               nearer;
    logic               emit_load;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [15:0]        ram_wdata;
    logic [15:0]        ram_rdata;

    // Saturate the screen size to the store size
    always_comb begin
        w = (WW'(i_cfg.screen_width) > WW'(MAX_COLUMNS)) ?
            WW'(MAX_COLUMNS) : WW'(i_cfg.screen_width);
        h = (HW'(i_cfg.screen_height) > HW'(MAX_ROWS)) ?
            HW'(MAX_ROWS) : HW'(i_cfg.screen_height);
    end

    // Divider step, projection products, bounds and depth test
    always_comb begin
        ooz    = r_sat ? 16'hFFFF : r_quo;
        dtry   = {r_rem[33:0], 1'b0};
        dge    = dtry >= {1'b0, r_div};
        px     = r_mx * $signed({1'b0, ooz});
        py     = r_my * $signed({1'b0, ooz});
        x_neg  = r_sxp[58];
        y_neg  = r_syp[61];
        // a negative sum above -1.0 truncates to column or row zero
        ok_x   = x_neg ? ((&r_sxp[58:32]) && (|r_sxp[31:0]) && (w != '0))
                       : (r_sxp[57:32] < 26'(w));
        ok_y   = y_neg ? ((&r_syp[61:32]) && (|r_syp[31:0]) && (h != '0))
                       : (r_syp[60:32] < 29'(h));
        nearer = ooz > ram_rdata;
    end

    assign emit_load = (r_state == B_EMIT) && (!r_out_valid || i_ready);
    assign o_job_pop = (r_state == B_IDLE) && i_job_valid;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_CLEAR: begin
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (i_job_valid) begin
                    if (i_job.kind == KIND_CLEAR) begin
                        n_state = B_CLEAR;
                    end else if (i_job.fz_pos) begin
                        n_state = B_DIV;
                    end
                end
            end
            B_DIV: begin
                if (r_div_cnt == DCW'(DIV_STEPS - 1)) begin
                    n_state = B_PROJ;
                end
            end
            B_PROJ:  n_state = B_BOUND;
            B_BOUND: n_state = (ok_x && ok_y) ? B_ADDR : B_IDLE;
            B_ADDR:  n_state = B_READ;
            B_READ:  n_state = B_TEST;
            B_TEST:  n_state = nearer ? B_EMIT : B_IDLE;
            B_EMIT: begin
                if (emit_load) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Control registers; a clearing pass starts at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr_addr  <= '0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= (r_state == B_CLEAR) ? r_clr_addr + 1'b1 : '0;
            r_div_cnt  <= (r_state == B_DIV) ? r_div_cnt + 1'b1 : '0;
            if (emit_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_div   <= i_job.fz16;
            r_sat   <= i_job.fz16 <= SAT_DEPTH;
            r_rem   <= 35'd65536;
            r_quo   <= '0;
            r_mx    <= i_job.rx8 * $signed({1'b0, i_cfg.zoom});
            r_my    <= i_job.fy8 * $signed({1'b0, i_cfg.zoom});
            r_level <= i_job.level;
        end
        if (r_state == B_DIV) begin
            r_rem <= dge ? dtry - {1'b0, r_div} : dtry;
            r_quo <= {r_quo[14:0], dge};
        end
        if (r_state == B_PROJ) begin
            r_sxp <= 59'($signed({1'b0, w, 31'd0})) + 59'($signed({px, 1'b0}));
            r_syp <= 62'($signed({1'b0, h, 31'd0})) - 62'(py);
        end
        if (r_state == B_BOUND) begin
            r_col <= x_neg ? '0 : r_sxp[32 +: CI];
            r_row <= y_neg ? '0 : r_syp[32 +: RI];
        end
        if (r_state == B_ADDR) begin
            r_idx <= AW'(r_col) + AW'(w) * AW'(r_row);
        end
        if (emit_load) begin
            r_out_cell  <= 15'(r_idx);
            r_out_shade <= r_level;
        end
    end

    // Depth store port: clearing sweep or depth update
    always_comb begin
        ram_we    = (r_state == B_CLEAR) || ((r_state == B_TEST) && nearer);
        ram_waddr = (r_state == B_CLEAR) ? r_clr_addr : r_idx;
        ram_wdata = (r_state == B_CLEAR) ? 16'd0 : ooz;
    end

    ppds_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_depth (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign o_clearing    = (r_state == B_CLEAR);
    assign o_valid       = r_out_valid;
    assign o_cell_index  = r_out_cell;
    assign o_shade_index = r_out_shade;

endmodule

### design/point_project_depth_shade_core.sv
// ----------------------------------------------------------------------------
// point_project_depth_shade_core
// Projects surface points onto a depth-tested cell grid with a shade level.
// ----------------------------------------------------------------------------
// Flow: the front end takes one item, runs it through its multiply/add
// chain and pushes it into a two-entry queue; it takes no new item until
// the push. The back end takes a job, runs the one-bit-per-cycle reciprocal
// divider, then projection, bounds, address, depth read, test and emit, and
// takes no new job before it is done; points behind the camera, off screen
// or hidden leave earlier. A clear item sweeps the depth store at one entry
// a cycle, MAX_COLUMNS*MAX_ROWS entries (32768 by default). The same sweep
// runs after reset, and no item is taken until it is done; configuration
// writes are taken at any time.
// ----------------------------------------------------------------------------
module point_project_depth_shade_core #(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // cfg write port
    input  logic                                i_cfg_we,
    input  logic [ppds_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ppds_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input items
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // point_x, point_y, point_z, normal_x, normal_y, normal_z (16 bits each)
    input  logic [95:0]                         i_s_tdata,
    // kind
    input  logic                                i_s_tuser,
    // result items
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // cell_index [14:0], shade_index [20:15], zero fill [23:21]
    output logic [23:0]                         o_m_tdata
);
    import ppds_pkg::*;

    t_cfg   r_cfg;
    t_point point;
    t_job   push_job;
    t_job   head_job;
    logic   push, full, pop, empty, clearing;
    logic [14:0] cell_idx;
    logic [5:0]  shade;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rotation       <= RST_ROTATION;
            r_cfg.zoom           <= RST_ZOOM;
            r_cfg.tilt           <= RST_TILT;
            r_cfg.light          <= RST_LIGHT;
            r_cfg.contrast       <= RST_CONTRAST;
            r_cfg.screen_width   <= RST_WIDTH;
            r_cfg.screen_height  <= RST_HEIGHT;
            r_cfg.palette_length <= RST_PALETTE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ROTATION: r_cfg.rotation       <= i_cfg_data;
                REG_ZOOM:     r_cfg.zoom           <= i_cfg_data[15:0];
                REG_TILT:     r_cfg.tilt           <= i_cfg_data[15:0];
                REG_LIGHT:    r_cfg.light          <= i_cfg_data[31:0];
                REG_CONTRAST: r_cfg.contrast       <= i_cfg_data[15:0];
                REG_WIDTH:    r_cfg.screen_width   <= i_cfg_data[8:0];
                REG_HEIGHT:   r_cfg.screen_height  <= i_cfg_data[7:0];
                REG_PALETTE:  r_cfg.palette_length <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Unpack the input item
    always_comb begin
        point.kind     = i_s_tuser;
        point.point_x  = i_s_tdata[15:0];
        point.point_y  = i_s_tdata[31:16];
        point.point_z  = i_s_tdata[47:32];
        point.normal_x = i_s_tdata[63:48];
        point.normal_y = i_s_tdata[79:64];
        point.normal_z = i_s_tdata[95:80];
    end

    ppds_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_hold  (clearing),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_point (point),
        .o_push  (push),
        .o_job   (push_job),
        .i_full  (full)
    );

    ppds_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (head_job),
        .o_empty (empty)
    );

    ppds_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_job_valid   (!empty),
        .i_job         (head_job),
        .o_job_pop     (pop),
        .o_clearing    (clearing),
        .o_valid       (o_m_tvalid),
        .i_ready       (i_m_tready),
        .o_cell_index  (cell_idx),
        .o_shade_index (shade)
    );

    assign o_m_tdata = {3'd0, shade, cell_idx};

endmodule

### design/ppds_chk.sv
// ----------------------------------------------------------------------------
// ppds_chk
// Port-level checks of the projection core, bound to the top level.
// ----------------------------------------------------------------------------
module ppds_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // Fill bits above the shade field stay zero
    a_out_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[23:21] == 3'd0))
        else $error("nonzero fill bits in result");

    // One item at a time: ready drops after each accepted item
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("front end took a second item while busy");

    // Reset leaves no result pending
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind point_project_depth_shade_core ppds_chk u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
